>>> rtl/core/tmsg_pkg.sv
// Shared constants, codes and pipeline types of the text-mode scanline generator.
package tmsg_pkg;

	// Screen geometry and frame timing.
	localparam int TEXT_COLUMNS     = 48;
	localparam int TEXT_ROWS        = 32;
	localparam int LINES_PER_FRAME  = 312;
	localparam int VISIBLE_LINES    = 256;
	localparam int FRAME_READY_LINE = 281;

	// Store sizes and address widths.
	localparam int SCREEN_SIZE  = TEXT_COLUMNS * TEXT_ROWS;
	localparam int SCREEN_AW    = (SCREEN_SIZE > 1) ? $clog2(SCREEN_SIZE) : 1;
	localparam int FONT_SIZE    = 2048;
	localparam int FONT_AW      = $clog2(FONT_SIZE);
	localparam int PALETTE_SIZE = 8;

	// The clearing sweep covers the larger of the two memories.
	localparam int CLEAR_LEN = (SCREEN_SIZE > FONT_SIZE) ? SCREEN_SIZE : FONT_SIZE;
	localparam int CLEAR_W   = $clog2(CLEAR_LEN);

	localparam logic [23:0] GREY_COLOR = 24'hC0C0C0;

	// Request kinds carried by the mode field.
	typedef enum logic [1:0] {
		MODE_SCREEN  = 2'd0,
		MODE_FONT    = 2'd1,
		MODE_PALETTE = 2'd2,
		MODE_TICK    = 2'd3
	} tmsg_mode_t;

	// Per-column bookkeeping that travels alongside the memory reads.
	typedef struct packed {
		logic [5:0] col;
		logic [8:0] line;
		logic       row_ok;
		logic       irq;
		logic       rdy;
		logic       last;
	} tmsg_meta_t;

endpackage

>>> rtl/core/tmsg_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
module tmsg_ram #(
	parameter int Depth = 2048,
	parameter int Width = 8,
	parameter int AddrW = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	// Read data only moves when re is high, so a stalled reader keeps its word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/text_mode_scanline_generator.sv
// Top level of the text-mode scanline generator: handshakes, line timing and render pipeline.
//
//   channel   direction   handshake                payload
//   input     in          in_valid / in_ready      mode, address, data
//   result    out         out_valid / out_ready    column, scan_line, pattern, color,
//                                                  frame_interrupt, frame_ready, last
//   config    in          cfg_wen (no wait)        cfg_wdata (color_mode)
//
// A write request, or a tick on a line with no results, sends nothing down the pipeline. A
// visible-line tick streams 48 results, one per cycle unless the result channel stalls, through
// a three-stage pipeline set by the two dependent memory reads (screen RAM, then font store);
// the next request is taken once that pipeline drains.
// After reset a clearing pass over the larger memory zeroes both memories; in_ready is low
// meanwhile, configuration writes are taken as usual.
// A stalled result register freezes the whole pipeline, memory read ports included.
module text_mode_scanline_generator
	import tmsg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [10:0] address,
	input  logic [23:0] data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  column,
	output logic [8:0]  scan_line,
	output logic [7:0]  pattern,
	output logic [23:0] color,
	output logic        frame_interrupt,
	output logic        frame_ready,
	output logic        last
);

	// Configuration, line timing and palette.
	logic              color_mode_q;
	logic [8:0]        line_q;
	logic [23:0]       palette_q [PALETTE_SIZE];

	// Clearing pass state.
	logic               clr_active_q;
	logic [CLEAR_W-1:0] clr_cnt_q;

	// Stage 0: column sequencer that issues the screen read.
	logic       gen_active_q;
	logic [5:0] gen_col_q;
	logic [8:0] gen_line_q;
	logic       gen_irq_q;
	logic       gen_rdy_q;

	// Stages 1 and 2 wait on the screen and font read data respectively.
	logic       valid_s1;
	tmsg_meta_t meta_s1;
	logic       valid_s2;
	tmsg_meta_t meta_s2;
	logic [2:0] pal_s2;

	// Result register.
	logic        out_valid_q;
	logic [5:0]  column_q;
	logic [8:0]  scan_line_q;
	logic [7:0]  pattern_q;
	logic [23:0] color_q;
	logic        irq_q;
	logic        rdy_q;
	logic        last_q;

	logic       adv;
	logic       in_accept;
	tmsg_mode_t in_mode;
	logic [15:0] addr_ext;
	logic        tick_visible;
	logic [9:0]  line_inc;
	logic [8:0]  line_next;
	logic [5:0]  row;
	logic        gen_last;
	logic [12:0] scr_raddr_full;
	tmsg_meta_t  meta_s0;

	// Memory ports.
	logic                 scr_we;
	logic [SCREEN_AW-1:0] scr_waddr;
	logic [7:0]           scr_wdata;
	logic [SCREEN_AW-1:0] scr_raddr;
	logic [7:0]           scr_rdata;
	logic                 font_we;
	logic [FONT_AW-1:0]   font_waddr;
	logic [7:0]           font_wdata;
	logic [FONT_AW-1:0]   font_raddr;
	logic [7:0]           font_rdata;
	logic [7:0]           chr_s1;

	// Everything downstream of the sequencer moves only when the result register can load.
	assign adv = !out_valid_q || out_ready;

	// New requests wait until the clearing pass ends and the render pipeline is empty.
	// A result still sitting in the output register does not hold up a request.
	assign in_ready  = !clr_active_q && !gen_active_q && !valid_s1 && !valid_s2;
	assign in_accept = in_valid && in_ready;
	assign in_mode   = tmsg_mode_t'(mode);
	assign addr_ext  = {5'd0, address};

	assign tick_visible = (line_q < 9'(VISIBLE_LINES));
	assign line_inc     = {1'b0, line_q} + 10'd1;
	assign line_next    = (line_inc >= 10'(LINES_PER_FRAME)) ? 9'd0 : line_inc[8:0];

	// Screen RAM is column-major, so the cell of a column sits at col*rows + row.
	assign row            = gen_line_q[8:3];
	assign scr_raddr_full = {7'd0, gen_col_q} * 13'(TEXT_ROWS) + {7'd0, row};
	assign scr_raddr      = scr_raddr_full[SCREEN_AW-1:0];
	assign gen_last       = gen_irq_q || gen_rdy_q || (gen_col_q == 6'(TEXT_COLUMNS - 1));

	always_comb begin
		meta_s0.col    = gen_col_q;
		meta_s0.line   = gen_line_q;
		meta_s0.row_ok = ({1'b0, row} < 7'(TEXT_ROWS));
		meta_s0.irq    = gen_irq_q;
		meta_s0.rdy    = gen_rdy_q;
		meta_s0.last   = gen_last;
	end

	// Write ports: the clearing pass owns them after reset, requests afterwards.
	always_comb begin
		if (clr_active_q) begin
			scr_we     = (clr_cnt_q < CLEAR_W'(SCREEN_SIZE));
			scr_waddr  = clr_cnt_q[SCREEN_AW-1:0];
			scr_wdata  = 8'd0;
			font_we    = 1'b1;
			font_waddr = clr_cnt_q[FONT_AW-1:0];
			font_wdata = 8'd0;
		end else begin
			scr_we     = in_accept && (in_mode == MODE_SCREEN) &&
			             ({5'd0, address} < 16'(SCREEN_SIZE));
			scr_waddr  = addr_ext[SCREEN_AW-1:0];
			scr_wdata  = data[7:0];
			font_we    = in_accept && (in_mode == MODE_FONT);
			font_waddr = address[FONT_AW-1:0];
			font_wdata = data[7:0];
		end
	end

	// Rows below the screen read as character zero.
	assign chr_s1     = meta_s1.row_ok ? scr_rdata : 8'd0;
	assign font_raddr = {chr_s1, meta_s1.line[2:0]};

	tmsg_ram #(
		.Depth(SCREEN_SIZE),
		.Width(8),
		.AddrW(SCREEN_AW)
	) u_screen (
		.clk  (clk),
		.we   (scr_we),
		.waddr(scr_waddr),
		.wdata(scr_wdata),
		.re   (adv),
		.raddr(scr_raddr),
		.rdata(scr_rdata)
	);

	tmsg_ram #(
		.Depth(FONT_SIZE),
		.Width(8),
		.AddrW(FONT_AW)
	) u_font (
		.clk  (clk),
		.we   (font_we),
		.waddr(font_waddr),
		.wdata(font_wdata),
		.re   (adv),
		.raddr(font_raddr),
		.rdata(font_rdata)
	);

	// Clearing pass, configuration register, line counter and palette.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
			color_mode_q <= 1'b0;
			line_q       <= 9'd0;
			for (int i = 0; i < PALETTE_SIZE; i++) begin
				palette_q[i] <= 24'd0;
			end
		end else begin
			if (clr_active_q) begin
				if (clr_cnt_q == CLEAR_W'(CLEAR_LEN - 1)) begin
					clr_active_q <= 1'b0;
				end
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cfg_wen) begin
				color_mode_q <= cfg_wdata;
			end
			if (in_accept) begin
				unique case (in_mode)
					MODE_PALETTE: begin
						if (address < 11'(PALETTE_SIZE)) begin
							palette_q[address[2:0]] <= data;
						end
					end
					MODE_TICK: begin
						line_q <= line_next;
					end
					MODE_SCREEN, MODE_FONT: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Stage 0 sequencer. Event lines send a single token with column zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_active_q <= 1'b0;
			gen_col_q    <= 6'd0;
			gen_line_q   <= 9'd0;
			gen_irq_q    <= 1'b0;
			gen_rdy_q    <= 1'b0;
		end else begin
			if (in_accept && (in_mode == MODE_TICK)) begin
				gen_col_q  <= 6'd0;
				gen_line_q <= line_q;
				gen_irq_q  <= (line_q == 9'(VISIBLE_LINES));
				gen_rdy_q  <= (line_q == 9'(FRAME_READY_LINE));
				gen_active_q <= tick_visible || (line_q == 9'(VISIBLE_LINES)) ||
				                (line_q == 9'(FRAME_READY_LINE));
			end else if (gen_active_q && adv) begin
				if (gen_last) begin
					gen_active_q <= 1'b0;
				end else begin
					gen_col_q <= gen_col_q + 6'd1;
				end
			end
		end
	end

	// Stages 1 and 2 valid flags and the result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= gen_active_q;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// Pipeline payload; no reset needed.
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= meta_s0;
			meta_s2 <= meta_s1;
			pal_s2  <= chr_s1[7:5];
			if (valid_s2) begin
				column_q    <= meta_s2.col;
				scan_line_q <= meta_s2.line;
				irq_q       <= meta_s2.irq;
				rdy_q       <= meta_s2.rdy;
				last_q      <= meta_s2.last;
				if (meta_s2.irq || meta_s2.rdy) begin
					pattern_q <= 8'd0;
					color_q   <= 24'd0;
				end else begin
					pattern_q <= font_rdata;
					color_q   <= color_mode_q ? palette_q[pal_s2] : GREY_COLOR;
				end
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign column          = column_q;
	assign scan_line       = scan_line_q;
	assign pattern         = pattern_q;
	assign color           = color_q;
	assign frame_interrupt = irq_q;
	assign frame_ready     = rdy_q;
	assign last            = last_q;

	// A visible line closes only on its final column.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last && !frame_interrupt && !frame_ready) |->
		(column == 6'(TEXT_COLUMNS - 1)))
		else $error("visible line ended on a column other than the last");

	// Event results are single, blank and carry only one flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (frame_interrupt || frame_ready)) |->
		(last && !(frame_interrupt && frame_ready) && (pattern == 8'd0) &&
		 (column == 6'd0)))
		else $error("malformed frame event result");

	// A blocked result register must freeze the last pipeline stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !adv) |=> (valid_s2 && $stable(meta_s2)))
		else $error("pipeline moved while the result register was blocked");

	// The clearing pass ends exactly after covering both memories.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_active_q) |-> ($past(clr_cnt_q) == CLEAR_W'(CLEAR_LEN - 1)))
		else $error("clearing pass ended early");

endmodule
